// File: src/frpr_pkg.sv
// ----------------------------------------------------------------------------
// frpr_pkg
// Shared types, codes and the CRC-16/XMODEM byte update for the framed
// packet receiver.
// ----------------------------------------------------------------------------
package frpr_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;

    // wide enough to hold BUFFER_DEPTH itself at its largest value
    localparam int DEPTH_CMP_W = 17;

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;
    localparam logic [1:0] ST_CRC_ERR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_COMMAND = 2'd0;
    localparam logic [1:0] CFG_MAX_LENGTH       = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS    = 2'd2;

    localparam logic [7:0]  CMD_RESET     = 8'd0;
    localparam logic [8:0]  MAX_LEN_RESET = 9'd256;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    // frame markers
    localparam logic [7:0] MARK_SHORT = 8'h02;
    localparam logic [7:0] MARK_LONG  = 8'h03;
    localparam logic [7:0] MARK_STOP  = 8'h03;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [16:0] TICK_MAX = 17'h1FFFF;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [1:0] status;
        logic [8:0] length;
    } result_t;

    // CRC-16/XMODEM, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: src/frpr_buf.sv
// ----------------------------------------------------------------------------
// frpr_buf
// Payload memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module frpr_buf #(
    parameter int BUFFER_DEPTH = frpr_pkg::BUFFER_DEPTH_DEF,
    parameter int AW           = $clog2(BUFFER_DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [7:0]    rd_index,
    output logic [7:0]    rd_data
);
    import frpr_pkg::*;

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_q_reg;
    logic       rd_in_range_reg;
    logic       in_range;

    assign in_range = DEPTH_CMP_W'(rd_index) < DEPTH_CMP_W'(BUFFER_DEPTH);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read request
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg <= mem[AW'(rd_index)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_in_range_reg <= 1'b0;
        end else if (rd_en) begin
            rd_in_range_reg <= in_range;
        end
    end

    assign rd_data = rd_in_range_reg ? rd_q_reg : 8'h00;

endmodule

// File: src/frpr_ctrl.sv
// ----------------------------------------------------------------------------
// frpr_ctrl
// Frame parser: marker hunt, length check, CRC over the body, trailer check,
// tick timeout and configuration registers.
// ----------------------------------------------------------------------------
module frpr_ctrl #(
    parameter int BUFFER_DEPTH = frpr_pkg::BUFFER_DEPTH_DEF,
    parameter int AW           = $clog2(BUFFER_DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wr_data,
    input  logic              accept,
    input  logic [1:0]        action,
    input  logic [7:0]        data_byte,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [7:0]        wr_data,
    output frpr_pkg::result_t res
);
    import frpr_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HUNT,
        PH_LEN_SHORT,
        PH_LEN_HIGH,
        PH_LEN_LOW,
        PH_BODY,
        PH_CRC_HIGH,
        PH_CRC_LOW,
        PH_STOP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [15:0] byte_cnt_reg, byte_cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [16:0] ticks_reg, ticks_next;
    logic [7:0]  first_byte_reg, first_byte_next;

    logic [7:0]  exp_cmd_reg;
    logic [8:0]  max_len_reg;
    logic [15:0] timeout_reg;

    logic [DEPTH_CMP_W-1:0] len_limit;
    logic [15:0]            len_cand;
    logic [15:0]            byte_cnt_inc;
    logic [16:0]            ticks_inc;

    assign len_limit = (DEPTH_CMP_W'(max_len_reg) > DEPTH_CMP_W'(BUFFER_DEPTH)) ?
                       DEPTH_CMP_W'(BUFFER_DEPTH) : DEPTH_CMP_W'(max_len_reg);
    assign len_cand     = (phase_reg == PH_LEN_SHORT) ? {8'h00, data_byte}
                                                      : {frame_len_reg[15:8], data_byte};
    assign byte_cnt_inc = byte_cnt_reg + 16'd1;
    assign ticks_inc    = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 17'd1;

    assign wr_addr = byte_cnt_reg[AW-1:0];
    assign wr_data = data_byte;

    always_comb begin
        phase_next      = phase_reg;
        frame_len_next  = frame_len_reg;
        byte_cnt_next   = byte_cnt_reg;
        crc_next        = crc_reg;
        crc_hi_next     = crc_hi_reg;
        crc_lo_next     = crc_lo_reg;
        ticks_next      = ticks_reg;
        first_byte_next = first_byte_reg;
        wr_en           = 1'b0;
        res             = '0;

        if (accept) begin
            unique case (action)
                ACT_START: begin
                    ticks_next = '0;
                    phase_next = PH_HUNT;
                end
                ACT_BYTE: begin
                    unique case (phase_reg)
                        PH_IDLE: ;
                        PH_HUNT: begin
                            if (data_byte == MARK_SHORT) begin
                                phase_next = PH_LEN_SHORT;
                            end else if (data_byte == MARK_LONG) begin
                                phase_next = PH_LEN_HIGH;
                            end
                        end
                        PH_LEN_HIGH: begin
                            frame_len_next = {data_byte, 8'h00};
                            phase_next     = PH_LEN_LOW;
                        end
                        PH_LEN_SHORT, PH_LEN_LOW: begin
                            frame_len_next = len_cand;
                            if (len_cand == 16'd0 || DEPTH_CMP_W'(len_cand) > len_limit) begin
                                res.valid  = 1'b1;
                                res.kind   = KIND_STATUS;
                                res.status = ST_BAD_LEN;
                                phase_next = PH_IDLE;
                            end else begin
                                byte_cnt_next = '0;
                                crc_next      = '0;
                                phase_next    = PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            wr_en = DEPTH_CMP_W'(byte_cnt_reg) < DEPTH_CMP_W'(BUFFER_DEPTH);
                            if (byte_cnt_reg == 16'd0) begin
                                first_byte_next = data_byte;
                            end
                            crc_next      = crc16_byte(crc_reg, data_byte);
                            byte_cnt_next = byte_cnt_inc;
                            if (byte_cnt_inc >= frame_len_reg) begin
                                phase_next = PH_CRC_HIGH;
                            end
                        end
                        PH_CRC_HIGH: begin
                            crc_hi_next = data_byte;
                            phase_next  = PH_CRC_LOW;
                        end
                        PH_CRC_LOW: begin
                            crc_lo_next = data_byte;
                            phase_next  = PH_STOP;
                        end
                        PH_STOP: begin
                            if (data_byte != MARK_STOP) begin
                                phase_next = PH_HUNT;
                            end else if ({crc_hi_reg, crc_lo_reg} != crc_reg) begin
                                res.valid  = 1'b1;
                                res.kind   = KIND_STATUS;
                                res.status = ST_CRC_ERR;
                                phase_next = PH_IDLE;
                            end else if (first_byte_reg != exp_cmd_reg) begin
                                phase_next = PH_HUNT;
                            end else begin
                                res.valid  = 1'b1;
                                res.kind   = KIND_STATUS;
                                res.status = ST_OK;
                                res.length = frame_len_reg[8:0];
                                phase_next = PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                ACT_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        ticks_next = ticks_inc;
                        if (ticks_inc > {1'b0, timeout_reg}) begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_STATUS;
                            res.status = ST_TIMEOUT;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                ACT_READ: begin
                    res.valid = 1'b1;
                    res.kind  = KIND_READ;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            frame_len_reg  <= '0;
            byte_cnt_reg   <= '0;
            crc_reg        <= '0;
            crc_hi_reg     <= '0;
            crc_lo_reg     <= '0;
            ticks_reg      <= '0;
            first_byte_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            frame_len_reg  <= frame_len_next;
            byte_cnt_reg   <= byte_cnt_next;
            crc_reg        <= crc_next;
            crc_hi_reg     <= crc_hi_next;
            crc_lo_reg     <= crc_lo_next;
            ticks_reg      <= ticks_next;
            first_byte_reg <= first_byte_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_cmd_reg <= CMD_RESET;
            max_len_reg <= MAX_LEN_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_EXPECTED_COMMAND: exp_cmd_reg <= cfg_wr_data[7:0];
                CFG_MAX_LENGTH:       max_len_reg <= cfg_wr_data[8:0];
                CFG_TIMEOUT_TICKS:    timeout_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

endmodule

// File: src/framed_packet_receiver_crc16_core.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16_core
// Framed serial reply receiver with CRC-16/XMODEM check and payload readback.
//
//   channel   dir  handshake             payload
//   s_        in   s_valid / s_ready     s_action, s_data_byte, s_read_index
//   m_        out  m_valid / m_ready     m_kind, m_status, m_payload_length,
//                                        m_read_data
//   cfg_      in   cfg_wr_en             cfg_index, cfg_wr_data
//
// One request per cycle while s_ready is high; a result passes the read stage,
// which waits on the memory's registered read, then the output register.
// Bytes write the memory and reads use it in separate requests, so the
// registered read needs no forwarding.
// Reset is synchronous; the payload memory has no clearing pass.
// While m_ready is low one more result is held in the read stage, then s_ready
// drops; requests without a result still pass while that stage is free.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16_core #(
    parameter int BUFFER_DEPTH = frpr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_status,
    output logic [8:0]  m_payload_length,
    output logic [7:0]  m_read_data
);
    import frpr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          accept;
    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;
    result_t       res;
    result_t       p_res_reg;
    logic          p_valid_reg;
    logic          m_valid_reg;
    logic          m_kind_reg;
    logic [1:0]    m_status_reg;
    logic [8:0]    m_len_reg;
    logic [7:0]    m_data_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !p_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    frpr_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .accept     (accept),
        .action     (s_action),
        .data_byte  (s_data_byte),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .res        (res)
    );

    frpr_buf #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .AW          (AW)
    ) u_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept && s_action == ACT_READ),
        .rd_index(s_read_index),
        .rd_data (rd_data)
    );

    // read stage: waits on the memory read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (accept) begin
            p_valid_reg <= res.valid;
        end else if (out_free) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && p_valid_reg) begin
            m_kind_reg   <= p_res_reg.kind;
            m_status_reg <= p_res_reg.status;
            m_len_reg    <= p_res_reg.length;
            m_data_reg   <= (p_res_reg.kind == KIND_READ) ? rd_data : 8'h00;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_status         = m_status_reg;
    assign m_payload_length = m_len_reg;
    assign m_read_data      = m_data_reg;

endmodule
